>>> rtl/bsvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsvt_pkg
// shared types and constants of the bone-selected vertex transform
// ----------------------------------------------------------------------------
package bsvt_pkg;

  localparam int MAT_WORDS  = 12;
  localparam int MADDR_W    = 12;
  localparam int ZERO_AMAX  = 10;
  localparam int ZERO_SUMSQ = 115;

  typedef enum logic [2:0] {
    FN_LOAD_WORD  = 3'd0,
    FN_LOAD_GROUP = 3'd1,
    FN_MAP        = 3'd2,
    FN_XFORM      = 3'd3,
    FN_CLEAR      = 3'd4
  } func_t;

  localparam logic [1:0] CFG_BONE_COUNT   = 2'd0;
  localparam logic [1:0] CFG_GROUP_COUNT  = 2'd1;
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd2;
  localparam logic [1:0] CFG_SKIN_ENABLE  = 2'd3;

  typedef struct packed {
    logic                 wr;
    logic                 pass;
    logic [MADDR_W-1:0]   maddr;
    logic [31:0]          wdata;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [31:0]   pz;
    logic signed [15:0]   nx;
    logic signed [15:0]   ny;
    logic signed [15:0]   nz;
  } job_t;

endpackage

>>> rtl/bsvt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsvt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module bsvt_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bsvt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsvt_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module bsvt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsvt_pkg::job_t  push_job,
  input  logic            pop,
  output bsvt_pkg::job_t  head,
  output logic            full,
  output logic            empty
);
  import bsvt_pkg::*;

  job_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign head  = ent_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> rtl/bsvt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsvt_front
// accepts items, keeps the group and vertex tables, queues matrix writes and
// transform jobs with their selected bone
// ----------------------------------------------------------------------------
module bsvt_front #(
  parameter int MAX_BONES  = 16,
  parameter int MAX_GROUPS = 64,
  parameter int MAX_VERTS  = 4096,
  parameter int NBW        = $clog2(MAX_BONES + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [199:0]    in_tdata,
  input  logic [2:0]      in_tuser,
  input  logic [NBW-1:0]  nb,
  input  logic [6:0]      group_count,
  input  logic [12:0]     vertex_count,
  input  logic            skin_enable,
  input  logic            q_full,
  output logic            push,
  output bsvt_pkg::job_t  push_job
);
  import bsvt_pkg::*;

  localparam int VAW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int GAW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int BW  = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_MAP, F_XFORM} fstate_t;

  fstate_t            state_r;
  logic [VAW-1:0]     clr_cnt_r;
  logic               map_ok_r;
  logic [11:0]        vi_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [15:0] nx_r, ny_r, nz_r;

  func_t              func;
  logic [5:0]         slot;
  logic [3:0]         wsel;
  logic [31:0]        val;
  logic [11:0]        vi;
  logic               accept;
  logic               word_ok;
  logic               map_ok;

  logic               g_we;
  logic [7:0]         g_wdata;
  logic [7:0]         g_rdata;
  logic               v_we;
  logic [VAW-1:0]     v_waddr;
  logic [BW-1:0]      v_wdata;
  logic [BW-1:0]      v_rdata;
  logic [BW-1:0]      bsel;

  assign func = func_t'(in_tuser);
  assign slot = in_tdata[5:0];
  assign wsel = in_tdata[9:6];
  assign val  = in_tdata[41:10];
  assign vi   = in_tdata[53:42];

  assign in_tready = (state_r == F_IDLE) && !q_full;
  assign accept    = in_tvalid && in_tready;

  assign word_ok = (int'(slot) < MAX_BONES) && (int'(wsel) < MAT_WORDS);
  assign map_ok  = skin_enable && (int'(nb) > 1) && ({1'b0, slot} < group_count) &&
                   (int'(slot) < MAX_GROUPS) && ({1'b0, vi} < vertex_count) &&
                   (int'(vi) < MAX_VERTS);

  assign g_we    = accept && (func == FN_LOAD_GROUP) && (int'(slot) < MAX_GROUPS);
  assign g_wdata = (|val[31:8]) ? 8'hFF : val[7:0];

  bsvt_ram #(.W(8), .D(MAX_GROUPS)) u_group_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (GAW'(slot)),
    .wdata (g_wdata),
    .raddr (GAW'(slot)),
    .rdata (g_rdata)
  );

  assign v_we    = (state_r == F_CLEAR) ||
                   ((state_r == F_MAP) && map_ok_r && (int'(g_rdata) < int'(nb)));
  assign v_waddr = (state_r == F_CLEAR) ? clr_cnt_r : VAW'(vi_r);
  assign v_wdata = (state_r == F_CLEAR) ? '0 : BW'(g_rdata);

  bsvt_ram #(.W(BW), .D(MAX_VERTS)) u_vertex_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (VAW'(vi)),
    .rdata (v_rdata)
  );

  // unmapped or out-of-range bones fall back to bone zero
  always_comb begin
    bsel = (int'(vi_r) < MAX_VERTS) ? v_rdata : '0;
    if (!((bsel != '0) && (int'(bsel) < int'(nb)))) begin
      bsel = '0;
    end
  end

  always_comb begin
    push_job    = '0;
    push_job.px = px_r;
    push_job.py = py_r;
    push_job.pz = pz_r;
    push_job.nx = nx_r;
    push_job.ny = ny_r;
    push_job.nz = nz_r;
    push        = 1'b0;
    if (state_r == F_XFORM) begin
      push           = 1'b1;
      push_job.pass  = (nb == '0);
      push_job.maddr = MADDR_W'(int'(bsel) * MAT_WORDS);
    end else if (accept && (func == FN_LOAD_WORD) && word_ok) begin
      push           = 1'b1;
      push_job.wr    = 1'b1;
      push_job.maddr = MADDR_W'(int'(slot) * MAT_WORDS + int'(wsel));
      push_job.wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vi_r <= vi;
      px_r <= signed'(in_tdata[85:54]);
      py_r <= signed'(in_tdata[117:86]);
      pz_r <= signed'(in_tdata[149:118]);
      nx_r <= signed'(in_tdata[165:150]);
      ny_r <= signed'(in_tdata[181:166]);
      nz_r <= signed'(in_tdata[197:182]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_CLEAR;
      clr_cnt_r <= '0;
      map_ok_r  <= 1'b0;
    end else begin
      case (state_r)
        F_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + VAW'(1);
          if (clr_cnt_r == VAW'(MAX_VERTS - 1)) begin
            state_r <= F_IDLE;
          end
        end
        F_IDLE: begin
          if (accept) begin
            case (func)
              FN_MAP: begin
                map_ok_r <= map_ok;
                state_r  <= F_MAP;
              end
              FN_XFORM: state_r <= F_XFORM;
              FN_CLEAR: begin
                clr_cnt_r <= '0;
                state_r   <= F_CLEAR;
              end
              default: state_r <= F_IDLE;
            endcase
          end
        end
        F_MAP:   state_r <= F_IDLE;
        F_XFORM: state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/bsvt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsvt_back
// matrix store, serial multiply-accumulate, normal scaling, square root and
// division, output register
// ----------------------------------------------------------------------------
module bsvt_back #(
  parameter int MAX_BONES = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  bsvt_pkg::job_t  q_head,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [143:0]    out_tdata,
  output logic [0:0]      out_tuser
);
  import bsvt_pkg::*;

  localparam int MD  = MAX_BONES * MAT_WORDS;
  localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_POS, B_ZCHK, B_SCALE, B_SQ, B_SQRT, B_DLD, B_DIV, B_OUT
  } bstate_t;

  function automatic logic [1:0] word_row(input logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd6, 4'd9:  word_row = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10: word_row = 2'd1;
      default:                 word_row = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] word_col(input logic [3:0] k);
    case (k)
      4'd0, 4'd1, 4'd2:  word_col = 2'd0;
      4'd3, 4'd4, 4'd5:  word_col = 2'd1;
      4'd6, 4'd7, 4'd8:  word_col = 2'd2;
      default:           word_col = 2'd3;
    endcase
  endfunction

  bstate_t            state_r;
  job_t               job_r;
  logic [3:0]         k_r, k1_r, k2_r;
  logic               v1_r, v2_r;
  logic [1:0]         row2_r;
  logic signed [63:0] pprod_r;
  logic signed [47:0] nprod_r;
  logic signed [65:0] acc_p_r [3];
  logic signed [49:0] acc_n_r [3];
  logic [48:0]        a_r [3];
  logic [2:0]         sgn_r;
  logic [1:0]         i_r;
  logic [41:0]        ssum_r;
  logic [41:0]        res_r;
  logic [41:0]        bit_r;
  logic [21:0]        rem_r;
  logic [16:0]        nq_r;
  logic [4:0]         j_r;
  logic signed [31:0] res_p_r [3];
  logic signed [15:0] res_n_r [3];
  logic               zero_r;
  logic               out_valid_r;
  logic [143:0]       out_data_r;
  logic               out_zero_r;

  logic [MADDR_W-1:0] rd_word;
  logic [31:0]        m_rdata;
  logic signed [31:0] w_s;
  logic [1:0]         col1;
  logic signed [31:0] psel;
  logic signed [15:0] nsel;
  logic signed [63:0] pm;
  logic signed [47:0] nm;
  logic [48:0]        amax;
  logic               near_zero;
  logic [9:0]         sumsq_small;
  logic [20:0]        len;
  logic [21:0]        den;
  logic [35:0]        num;
  logic [22:0]        rem2;
  logic               qbit;
  logic [16:0]        q;
  logic [14:0]        q_sat;
  logic [41:0]        trial;

  assign pop = (state_r == B_IDLE) && !q_empty;

  assign rd_word = job_r.maddr + MADDR_W'(k_r);

  bsvt_ram #(.W(32), .D(MD)) u_matrix_ram (
    .clk   (clk),
    .we    (pop && q_head.wr),
    .waddr (MAW'(q_head.maddr)),
    .wdata (q_head.wdata),
    .raddr (MAW'(rd_word)),
    .rdata (m_rdata)
  );

  assign w_s  = signed'(m_rdata);
  assign col1 = word_col(k1_r);

  always_comb begin
    case (col1)
      2'd0: begin psel = job_r.px; nsel = job_r.nx; end
      2'd1: begin psel = job_r.py; nsel = job_r.ny; end
      default: begin psel = job_r.pz; nsel = job_r.nz; end
    endcase
    pm = w_s * psel;
    nm = w_s * nsel;
    if (col1 == 2'd3) begin
      pm = {{16{w_s[31]}}, w_s, 16'b0};
      nm = '0;
    end
  end

  always_comb begin
    amax = a_r[0];
    if (a_r[1] > amax) amax = a_r[1];
    if (a_r[2] > amax) amax = a_r[2];
    near_zero = (a_r[0] <= 49'(ZERO_AMAX)) && (a_r[1] <= 49'(ZERO_AMAX)) &&
                (a_r[2] <= 49'(ZERO_AMAX));
    sumsq_small = ({6'b0, a_r[0][3:0]} * {6'b0, a_r[0][3:0]}) +
                  ({6'b0, a_r[1][3:0]} * {6'b0, a_r[1][3:0]}) +
                  ({6'b0, a_r[2][3:0]} * {6'b0, a_r[2][3:0]});
  end

  assign len   = res_r[20:0];
  assign den   = {len, 1'b0};
  assign num   = {1'b0, a_r[i_r][19:0], 15'b0} + 36'(len);
  assign rem2  = {rem_r, nq_r[16]};
  assign qbit  = (rem2 >= 23'(den));
  assign q     = {nq_r[15:0], qbit};
  assign q_sat = (q > 17'd32767) ? 15'h7FFF : q[14:0];
  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == B_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop) begin
            job_r <= q_head;
            if (q_head.pass) begin
              res_p_r[0] <= q_head.px;
              res_p_r[1] <= q_head.py;
              res_p_r[2] <= q_head.pz;
              res_n_r[0] <= q_head.nx;
              res_n_r[1] <= q_head.ny;
              res_n_r[2] <= q_head.nz;
              zero_r     <= 1'b0;
              state_r    <= B_OUT;
            end else if (!q_head.wr) begin
              k_r  <= '0;
              v1_r <= 1'b0;
              v2_r <= 1'b0;
              for (int i = 0; i < 3; i++) begin
                acc_p_r[i] <= '0;
                acc_n_r[i] <= '0;
              end
              state_r <= B_LOAD;
            end
          end
        end
        B_LOAD: begin
          v1_r <= (k_r < 4'(MAT_WORDS));
          k1_r <= k_r;
          if (k_r < 4'(MAT_WORDS)) begin
            k_r <= k_r + 4'd1;
          end
          v2_r    <= v1_r;
          k2_r    <= k1_r;
          row2_r  <= word_row(k1_r);
          pprod_r <= pm;
          nprod_r <= nm;
          if (v2_r) begin
            acc_p_r[row2_r] <= acc_p_r[row2_r] + 66'(pprod_r);
            acc_n_r[row2_r] <= acc_n_r[row2_r] + 50'(nprod_r);
            if (k2_r == 4'(MAT_WORDS - 1)) begin
              state_r <= B_POS;
            end
          end
        end
        B_POS: begin
          for (int i = 0; i < 3; i++) begin
            logic signed [65:0] t;
            t = (acc_p_r[i] + 66'sd32768) >>> 16;
            if (t > 66'sd2147483647) begin
              res_p_r[i] <= 32'sh7FFFFFFF;
            end else if (t < -66'sd2147483648) begin
              res_p_r[i] <= 32'sh80000000;
            end else begin
              res_p_r[i] <= t[31:0];
            end
            sgn_r[i] <= acc_n_r[i][49];
            a_r[i]   <= acc_n_r[i][49] ? 49'(-acc_n_r[i]) : acc_n_r[i][48:0];
          end
          state_r <= B_ZCHK;
        end
        B_ZCHK: begin
          if (near_zero && (sumsq_small <= 10'(ZERO_SUMSQ))) begin
            for (int i = 0; i < 3; i++) begin
              res_n_r[i] <= '0;
            end
            zero_r  <= 1'b1;
            state_r <= B_OUT;
          end else begin
            zero_r  <= 1'b0;
            state_r <= B_SCALE;
          end
        end
        B_SCALE: begin
          if (amax >= 49'(1) << 20) begin
            for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] >> 1;
          end else if (amax < 49'(1) << 19) begin
            for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] << 1;
          end else begin
            i_r     <= 2'd0;
            ssum_r  <= '0;
            state_r <= B_SQ;
          end
        end
        B_SQ: begin
          ssum_r <= ssum_r + ({22'b0, a_r[i_r][19:0]} * {22'b0, a_r[i_r][19:0]});
          i_r    <= i_r + 2'd1;
          if (i_r == 2'd2) begin
            res_r   <= '0;
            bit_r   <= 42'(1) << 40;
            state_r <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (ssum_r >= trial) begin
            ssum_r <= ssum_r - trial;
            res_r  <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == 42'd1) begin
            i_r     <= 2'd0;
            state_r <= B_DLD;
          end
        end
        B_DLD: begin
          rem_r   <= 22'(num[35:17]);
          nq_r    <= num[16:0];
          j_r     <= 5'd17;
          state_r <= B_DIV;
        end
        B_DIV: begin
          rem_r <= qbit ? 22'(rem2 - 23'(den)) : rem2[21:0];
          nq_r  <= q;
          j_r   <= j_r - 5'd1;
          if (j_r == 5'd1) begin
            res_n_r[i_r] <= sgn_r[i_r] ? -signed'({1'b0, q_sat}) : signed'({1'b0, q_sat});
            i_r <= i_r + 2'd1;
            state_r <= (i_r == 2'd2) ? B_OUT : B_DLD;
          end
        end
        B_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {res_n_r[2], res_n_r[1], res_n_r[0],
                            res_p_r[2], res_p_r[1], res_p_r[0]};
            out_zero_r  <= zero_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

endmodule

>>> rtl/bone_selected_vertex_transform_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bone_selected_vertex_transform_top
// per-bone 4x3 affine transform of position and normal, bone chosen per vertex
// ----------------------------------------------------------------------------
// a transform runs a 12-word serial multiply-accumulate, up to 29 scaling steps,
// a 21-step square root and three 17-step divisions; a zero normal skips the
// scaling, root and divisions, and a pass-through skips all of them
// the back end works on one job at a time and pops the next only once idle again
// reset: a clearing sweep over all MAX_VERTS entries of the vertex table runs after
// reset and after each clear item, with in_tready low meanwhile
// ----------------------------------------------------------------------------
module bone_selected_vertex_transform_top #(
  parameter int MAX_BONES  = 16,
  parameter int MAX_GROUPS = 64,
  parameter int MAX_VERTS  = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // slot, word_sel, value, vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  input  logic [199:0]  in_tdata,
  // func
  input  logic [2:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_x, out_y, out_z, out_nx, out_ny, out_nz
  output logic [143:0]  out_tdata,
  // zero_normal
  output logic [0:0]    out_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data
);
  import bsvt_pkg::*;

  localparam int NBW = $clog2(MAX_BONES + 1);

  logic [4:0]     bone_count_r;
  logic [6:0]     group_count_r;
  logic [12:0]    vertex_count_r;
  logic           skin_enable_r;
  logic [NBW-1:0] nb;
  logic           push, pop, q_full, q_empty;
  job_t           push_job, q_head;

  assign cfg_ready = 1'b1;
  assign nb = (int'(bone_count_r) > MAX_BONES) ? NBW'(MAX_BONES) : NBW'(bone_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r   <= '0;
      group_count_r  <= '0;
      vertex_count_r <= '0;
      skin_enable_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BONE_COUNT:   bone_count_r   <= cfg_data[4:0];
        CFG_GROUP_COUNT:  group_count_r  <= cfg_data[6:0];
        CFG_VERTEX_COUNT: vertex_count_r <= cfg_data;
        CFG_SKIN_ENABLE:  skin_enable_r  <= cfg_data[0];
        default:          skin_enable_r  <= skin_enable_r;
      endcase
    end
  end

  bsvt_front #(
    .MAX_BONES  (MAX_BONES),
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_VERTS  (MAX_VERTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .nb           (nb),
    .group_count  (group_count_r),
    .vertex_count (vertex_count_r),
    .skin_enable  (skin_enable_r),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  bsvt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  bsvt_back #(.MAX_BONES(MAX_BONES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_full || pop))
    else $error("job pushed into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !q_full)
    else $error("item taken while queue full");

endmodule
